// ===== rtl/rcpe_pkg.sv =====
package rcpe_pkg;

  // input command codes (carried on in_tuser)
  localparam logic [1:0] CMD_CHAR  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_NONE     = 2'd0;
  localparam logic [1:0] ST_ACCEPTED = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // configuration register indexes
  localparam logic CFG_ROM_READY  = 1'b0;
  localparam logic CFG_BANK_COUNT = 1'b1;

  localparam int          CODE_DEPTH  = 11;
  localparam logic [3:0]  CHAR_MAX    = 4'hF;
  localparam logic [8:0]  MAX_BANKS   = 9'd256;
  localparam int          OFF_W       = 14;

  // one stored cheat
  typedef struct packed {
    logic             has_cmp;
    logic [7:0]       cmp;
    logic [OFF_W-1:0] off;
    logic [7:0]       newv;
  } cheat_t;

  // read token walking down the cell chain
  typedef struct packed {
    logic             vld;
    logic             act;
    logic [OFF_W-1:0] off;
    logic [7:0]       data;
  } tok_t;

  function automatic logic [3:0] digit(input logic [7:0] c);
    logic [7:0] t;
    begin
      if (c >= 8'h41) t = c - 8'h37;
      else            t = c - 8'h30;
      digit = t[3:0];
    end
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    is_sep = (c < 8'h30) || ((c > 8'h39) && (c < 8'h41));
  endfunction

  // scrambled compare byte from two digits
  function automatic logic [7:0] scramble(input logic [3:0] hi, input logic [3:0] lo);
    logic [7:0] v;
    begin
      v = {hi, lo} ^ 8'hFF;
      scramble = {v[1:0], v[7:2]} ^ 8'h45;
    end
  endfunction

endpackage

// ===== rtl/rom_cheat_patch_engine.sv =====
// Cheat code decoder and ROM read patcher. Code characters arrive on the input
// stream with in_tuser = character command, in_tlast marking the final character;
// letters are uppercased and the code is decoded when the last character lands.
// A decoded cheat is appended to a chain of MAX_CHEATS cells, one cheat per cell,
// in the order accepted; once every cell is taken further valid codes report table full.
// A ROM read enters the head of the chain and moves one cell per cycle, each cell
// substituting its value when offset, bank range and optional compare byte match,
// so later cheats override earlier ones. A clear command empties the table.
// Every input transaction produces exactly one output transaction. One transaction
// is worked on at a time: a ROM read walks down the cell chain and then hands off
// its result, a final code character goes through buffer write, decode and
// hand-off, and any other command goes straight to the hand-off; a result stalled
// on the output side holds up the next hand-off. The output register lets the next
// input be taken while the previous result is still waiting.
module rom_cheat_patch_engine #(
  parameter int MAX_CHEATS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // code_char[7:0], rom_address[29:8], rom_byte[37:30]
  input  logic [1:0]  in_tuser,   // command[1:0]
  input  logic        in_tlast,   // code_last
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // read_byte[7:0], status[9:8]
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int CNT_W = $clog2(MAX_CHEATS + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECODE = 4'b0010,
    S_WALK   = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic             rom_ready_r;
  logic [8:0]       bank_count_r;
  logic [7:0]       code_buf_r [rcpe_pkg::CODE_DEPTH];
  logic [3:0]       char_cnt_r, char_cnt_nxt;
  logic [CNT_W-1:0] cheat_cnt_r, cheat_cnt_nxt;
  logic [7:0]       res_byte_r, res_byte_nxt;
  logic [1:0]       res_st_r, res_st_nxt;
  logic             out_tvalid_r;
  logic [7:0]       out_byte_r;
  logic [1:0]       out_st_r;

  logic             accept;
  logic [7:0]       in_char, char_up;
  logic [21:0]      in_addr;
  logic [7:0]       in_byte;
  logic [7:0]       bank;
  logic             buf_we, tbl_we;
  logic             out_load;

  // decode path
  logic [3:0]       d [rcpe_pkg::CODE_DEPTH];
  logic             code_ok, table_full;
  rcpe_pkg::cheat_t new_entry;

  // cell chain
  rcpe_pkg::tok_t   chain [MAX_CHEATS+1];

  assign accept  = in_tvalid && in_tready;
  assign in_char = in_tdata[7:0];
  assign in_addr = in_tdata[29:8];
  assign in_byte = in_tdata[37:30];
  assign bank    = in_addr[21:14];

  // uppercase letters
  assign char_up = ((in_char >= 8'h61) && (in_char <= 8'h7A)) ? in_char - 8'h20 : in_char;

  assign in_tready = (state_r == S_IDLE);

  // digits of the buffered code
  for (genvar k = 0; k < rcpe_pkg::CODE_DEPTH; k++) begin : g_dig
    assign d[k] = rcpe_pkg::digit(code_buf_r[k]);
  end

  assign code_ok    = rom_ready_r && (char_cnt_r > 4'd6) && rcpe_pkg::is_sep(code_buf_r[3]);
  assign table_full = (cheat_cnt_r == CNT_W'(MAX_CHEATS));

  always_comb begin
    new_entry.newv    = {d[0], d[1]};
    new_entry.off     = {~d[6][1:0], d[2], d[4], d[5]};
    // only an exact eleven-character code with a second separator has a compare
    new_entry.has_cmp = (char_cnt_r == 4'd11) && rcpe_pkg::is_sep(code_buf_r[7]);
    new_entry.cmp     = new_entry.has_cmp ? rcpe_pkg::scramble(d[8], d[10]) : 8'h00;
  end

  // read token enters the chain head in the cycle it is accepted
  always_comb begin
    chain[0].vld  = accept && (in_tuser == rcpe_pkg::CMD_READ);
    chain[0].act  = ({1'b0, bank} < bank_count_r) && ({1'b0, bank} < rcpe_pkg::MAX_BANKS);
    chain[0].off  = in_addr[13:0];
    chain[0].data = in_byte;
  end

  for (genvar i = 0; i < MAX_CHEATS; i++) begin : g_cell
    rcpe_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (tbl_we && (cheat_cnt_r == CNT_W'(i))),
      .wr_entry (new_entry),
      .enable   (cheat_cnt_r > CNT_W'(i)),
      .tok_in   (chain[i]),
      .tok_out  (chain[i+1])
    );
  end

  assign out_load = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    char_cnt_nxt  = char_cnt_r;
    cheat_cnt_nxt = cheat_cnt_r;
    res_byte_nxt  = res_byte_r;
    res_st_nxt    = res_st_r;
    buf_we        = 1'b0;
    tbl_we        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_byte_nxt = 8'h00;
          res_st_nxt   = rcpe_pkg::ST_NONE;
          state_nxt    = S_DONE;
          unique case (in_tuser)
            rcpe_pkg::CMD_CHAR: begin
              buf_we = (char_cnt_r < 4'(rcpe_pkg::CODE_DEPTH));
              if (char_cnt_r != rcpe_pkg::CHAR_MAX) char_cnt_nxt = char_cnt_r + 4'd1;
              if (in_tlast) state_nxt = S_DECODE;
            end
            rcpe_pkg::CMD_CLEAR: cheat_cnt_nxt = '0;
            rcpe_pkg::CMD_READ:  state_nxt = S_WALK;
            default: ;
          endcase
        end
      end
      S_DECODE: begin
        char_cnt_nxt = 4'd0;
        state_nxt    = S_DONE;
        if (!code_ok) begin
          res_st_nxt = rcpe_pkg::ST_REJECTED;
        end else if (table_full) begin
          res_st_nxt = rcpe_pkg::ST_FULL;
        end else begin
          res_st_nxt    = rcpe_pkg::ST_ACCEPTED;
          tbl_we        = 1'b1;
          cheat_cnt_nxt = cheat_cnt_r + CNT_W'(1);
        end
      end
      S_WALK: begin
        // token leaves the last cell
        if (chain[MAX_CHEATS].vld) begin
          res_byte_nxt = chain[MAX_CHEATS].data;
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      char_cnt_r  <= 4'd0;
      cheat_cnt_r <= '0;
    end else begin
      state_r     <= state_nxt;
      char_cnt_r  <= char_cnt_nxt;
      cheat_cnt_r <= cheat_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_byte_r <= res_byte_nxt;
    res_st_r   <= res_st_nxt;
    if (buf_we) code_buf_r[char_cnt_r] <= char_up;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_ready_r  <= 1'b0;
      bank_count_r <= 9'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rcpe_pkg::CFG_ROM_READY:  rom_ready_r  <= cfg_data[0];
        rcpe_pkg::CFG_BANK_COUNT: bank_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r <= res_byte_r;
      out_st_r   <= res_st_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'd0, out_st_r, out_byte_r};

endmodule

// ===== rtl/rcpe_cell.sv =====
module rcpe_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  rcpe_pkg::cheat_t wr_entry,
  input  logic             enable,
  input  rcpe_pkg::tok_t   tok_in,
  output rcpe_pkg::tok_t   tok_out
);

  rcpe_pkg::cheat_t entry_r;
  rcpe_pkg::tok_t   tok_r;
  rcpe_pkg::tok_t   tok_nxt;
  logic             hit;

  // cheat applies when the cell holds a cheat, the bank is active, offset matches and the compare byte (if any) agrees
  assign hit = enable && tok_in.act && (entry_r.off == tok_in.off) &&
               (!entry_r.has_cmp || (entry_r.cmp == tok_in.data));

  always_comb begin
    tok_nxt = tok_in;
    if (hit) tok_nxt.data = entry_r.newv;
  end

  always_ff @(posedge clk) begin
    if (wr_en) entry_r <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.act  <= tok_nxt.act;
    tok_r.off  <= tok_nxt.off;
    tok_r.data <= tok_nxt.data;
  end

  assign tok_out = tok_r;

endmodule

// ===== rtl/rcpe_checker.sv =====
module rcpe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // a held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one transaction in flight: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while previous transaction in progress");

  // a code status never comes with a read byte
  a_status_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[9:8] != rcpe_pkg::ST_NONE) |-> out_tdata[7:0] == 8'h00)
    else $error("code status with nonzero read byte");

  // padding bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:10] == 6'd0)
    else $error("nonzero padding in result");

  // nothing offered right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind rom_cheat_patch_engine rcpe_checker u_rcpe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/rcpe_checker.sv =====
`timescale 1ns / 100ps

module rcpe_scoreboard #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // code_char[7:0], rom_address[29:8], rom_byte[37:30]
  input  logic [1:0]  in_tuser,   // command[1:0]
  input  logic        in_tlast,   // code_last
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // read_byte[7:0], status[9:8]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data,
  output int          mismatch_total,
  output int          pending,
  output int          reads_seen,
  output int          codes_taken,
  output int          codes_refused,
  output int          table_full_drops
);

  typedef struct packed {
    logic [7:0] read_byte;
    logic [1:0] status;
  } reply_t;

  typedef struct packed {
    logic       has_cmp;
    logic [7:0] cmp;
    logic [13:0] off;
    logic [7:0] newv;
  } patch_t;

  logic       rom_rdy;
  logic [8:0] bank_lim;
  logic [7:0] code_chars [0:rcpe_pkg::CODE_DEPTH-1];
  logic [3:0] char_cnt;
  patch_t     patches [0:TABLE_DEPTH-1];
  int         n_patches;
  reply_t     replies_due [$];

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    if (c >= 8'h41) t = c - 8'h41 + 8'd10;
    else t = c - 8'h30;
    return t[3:0];
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return (c < 8'h30) || (c > 8'h39 && c < 8'h41);
  endfunction

  // byte after every stored patch in table order
  function automatic logic [7:0] patch_byte(input logic [21:0] addr, input logic [7:0] rb);
    logic [7:0] b;
    b = rb;
    if ({1'b0, addr[21:14]} < bank_lim) begin
      for (int i = 0; i < n_patches; i++) begin
        if (patches[i].off == addr[13:0] && (!patches[i].has_cmp || patches[i].cmp == b))
          b = patches[i].newv;
      end
    end
    return b;
  endfunction

  task automatic close_code(output logic [1:0] st);
    logic [3:0] d6x;
    logic [7:0] v;
    patch_t p;
    if (!rom_rdy || char_cnt <= 4'd6 || !is_delim(code_chars[3])) begin
      st = rcpe_pkg::ST_REJECTED;
    end else begin
      d6x = hex_val(code_chars[6]) ^ 4'hF;
      p.newv = {hex_val(code_chars[0]), hex_val(code_chars[1])};
      p.off = {d6x[1:0], hex_val(code_chars[2]), hex_val(code_chars[4]),
               hex_val(code_chars[5])};
      p.has_cmp = 1'b0;
      p.cmp = 8'h00;
      if (char_cnt == 4'd11 && is_delim(code_chars[7])) begin
        v = {hex_val(code_chars[8]), hex_val(code_chars[10])} ^ 8'hFF;
        p.cmp = {v[1:0], v[7:2]} ^ 8'h45;
        p.has_cmp = 1'b1;
      end
      if (n_patches >= TABLE_DEPTH) begin
        st = rcpe_pkg::ST_FULL;
      end else begin
        patches[n_patches] = p;
        n_patches++;
        st = rcpe_pkg::ST_ACCEPTED;
      end
    end
  endtask

  task automatic compute_reply(input logic [1:0] cmd, input logic [7:0] ch, input logic last,
                               input logic [21:0] addr, input logic [7:0] rb,
                               output reply_t r);
    logic [7:0] c;
    logic [1:0] st;
    r = '0;
    case (cmd)
      rcpe_pkg::CMD_CHAR: begin
        c = ch;
        if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
        if (char_cnt < rcpe_pkg::CODE_DEPTH) code_chars[char_cnt] = c;
        if (char_cnt < rcpe_pkg::CHAR_MAX) char_cnt++;
        if (last) begin
          close_code(st);
          r.status = st;
          char_cnt = 4'd0;
        end
      end
      rcpe_pkg::CMD_CLEAR: n_patches = 0;
      rcpe_pkg::CMD_READ: r.read_byte = patch_byte(addr, rb);
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    reply_t r;
    reply_t want;
    if (!rst_n) begin
      rom_rdy = 1'b0;
      bank_lim = 9'd1;
      char_cnt = 4'd0;
      n_patches = 0;
      replies_due.delete();
      mismatch_total = 0;
      reads_seen = 0;
      codes_taken = 0;
      codes_refused = 0;
      table_full_drops = 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rcpe_pkg::CFG_ROM_READY: rom_rdy = cfg_data[0];
          rcpe_pkg::CFG_BANK_COUNT: bank_lim = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        compute_reply(in_tuser, in_tdata[7:0], in_tlast, in_tdata[29:8], in_tdata[37:30], r);
        replies_due = {replies_due, r};
        if (in_tuser == rcpe_pkg::CMD_READ) reads_seen++;
        case (r.status)
          rcpe_pkg::ST_ACCEPTED: codes_taken++;
          rcpe_pkg::ST_REJECTED: codes_refused++;
          rcpe_pkg::ST_FULL: table_full_drops++;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (replies_due.size() == 0) begin
          if (mismatch_total < 10)
            $display("unexpected result at %0t: tdata %04h", $time, out_tdata);
          mismatch_total++;
        end else begin
          want = replies_due.pop_front();
          if (out_tdata[7:0] != want.read_byte || out_tdata[9:8] != want.status) begin
            if (mismatch_total < 10)
              $display("mismatch at %0t: read_byte exp %02h got %02h, status exp %0d got %0d",
                       $time, want.read_byte, out_tdata[7:0], want.status, out_tdata[9:8]);
            mismatch_total++;
          end
        end
      end
      pending <= replies_due.size();
    end
  end

endmodule

// ===== tb/rom_cheat_patch_engine_test.sv =====
`timescale 1ns / 100ps

module rom_cheat_patch_engine_test;

  // spare command code, no effect in the block
  localparam logic [1:0] CMD_SPARE = 2'd3;
  // generous cycle budget, slowest legal run is far below this
  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // code_char[7:0], rom_address[29:8], rom_byte[37:30]
  logic [1:0]  in_tuser = '0;   // command[1:0]
  logic        in_tlast = 1'b0; // code_last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // read_byte[7:0], status[9:8]
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [8:0]  cfg_data = '0;

  int mismatch_total, pending;
  int reads_seen, codes_taken, codes_refused, table_full_drops;

  // stimulus knobs
  int items_sent = 0;
  int send_pct = 0;    // chance per transaction of an input gap burst
  int recv_pct = 0;    // chance per cycle of an output stall burst
  int cur_banks = 1;
  int stall_left = 0;
  int cycles = 0;

  // recently loaded cheats, used to aim reads at live offsets
  logic [13:0] aim_off [0:15];
  logic [7:0]  aim_new [0:15];
  logic [7:0]  aim_cmp [0:15];
  logic        aim_cmp_on [0:15];
  int          n_aim = 0;
  int          aim_wr = 0;

  rom_cheat_patch_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rcpe_scoreboard u_scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_total(mismatch_total), .pending(pending),
    .reads_seen(reads_seen), .codes_taken(codes_taken),
    .codes_refused(codes_refused), .table_full_drops(table_full_drops)
  );

  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still outstanding", cycles, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // output side back-pressure: random stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (recv_pct > 0 && $urandom_range(0, 99) < recv_pct) begin
      stall_left <= $urandom_range(0, 15);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic logic [7:0] rand8();
    logic [31:0] r;
    r = $urandom;
    return r[7:0];
  endfunction

  // hex digit as ascii, letters in random case
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) begin
      c = 8'h30 + {4'b0, v};
    end else begin
      c = 8'h41 + {4'b0, v} - 8'd10;
      if ($urandom_range(0, 1) == 1) c = c + 8'h20;
    end
    return c;
  endfunction

  // separator: below '0' or between '9' and 'A'
  function automatic logic [7:0] delim_char();
    logic [31:0] r;
    if ($urandom_range(0, 1) == 1) r = $urandom_range(0, 47);
    else r = $urandom_range(58, 64);
    return r[7:0];
  endfunction

  function automatic logic [7:0] plain_char();
    logic [31:0] r;
    if ($urandom_range(0, 1) == 1) r = $urandom_range(48, 57);
    else r = $urandom_range(65, 255);
    return r[7:0];
  endfunction

  // one input transaction, with an optional idle burst in front of it
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch, input logic last,
                           input logic [21:0] addr, input logic [7:0] rb);
    if (send_pct > 0 && $urandom_range(0, 99) < send_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tlast <= last;
    in_tdata <= {2'b00, rb, addr, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // register writes only once every result is back
  task automatic set_config(input logic ready, input int banks);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    cfg_we <= 1'b1;
    cfg_index <= rcpe_pkg::CFG_ROM_READY;
    cfg_data <= {8'd0, ready};
    @(posedge clk);
    cfg_index <= rcpe_pkg::CFG_BANK_COUNT;
    cfg_data <= banks[8:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_banks = banks;
  endtask

  // rom read, mostly aimed at an offset and bank that a loaded cheat covers
  task automatic random_read();
    logic [31:0] r;
    logic [13:0] off;
    logic [7:0]  rb;
    int k, bank, hi;
    r = $urandom;
    rb = rand8();
    off = r[13:0];
    if (n_aim > 0 && $urandom_range(0, 9) < 7) begin
      k = $urandom_range(0, n_aim - 1);
      off = aim_off[k];
      // hit the compare byte half of the time
      if (aim_cmp_on[k] && $urandom_range(0, 1) == 1) rb = aim_cmp[k];
    end
    hi = (cur_banks == 0) ? 0 : ((cur_banks > 256) ? 255 : cur_banks - 1);
    if ($urandom_range(0, 3) == 0) bank = $urandom_range(0, 255);
    else bank = $urandom_range(0, hi);
    send_item(rcpe_pkg::CMD_READ, r[21:14], r[22], {bank[7:0], off}, rb);
  endtask

  // build and send one code from the fields it should decode to
  task automatic send_code(input int len, input logic sep_ok, input logic with_cmp,
                           input logic [7:0] newv, input logic [13:0] off,
                           input logic [7:0] cmp, input logic noisy, input logic split);
    logic [7:0] chars [0:19];
    logic [7:0] w, x;
    logic [31:0] r;
    int p;
    for (int i = 0; i < 20; i++) chars[i] = rand8();
    r = $urandom;
    chars[0] = hex_char(newv[7:4]);
    chars[1] = hex_char(newv[3:0]);
    chars[2] = hex_char(off[11:8]);
    chars[3] = sep_ok ? delim_char() : plain_char();
    chars[4] = hex_char(off[7:4]);
    chars[5] = hex_char(off[3:0]);
    // low two bits of this digit carry the inverted offset top bits
    chars[6] = hex_char({r[1:0], ~off[13:12]});
    if (with_cmp) begin
      // undo the scramble: xor, rotate left by two, invert
      w = cmp ^ 8'h45;
      x = {w[5:0], w[7:6]} ^ 8'hFF;
      chars[7] = delim_char();
      chars[8] = hex_char(x[7:4]);
      chars[10] = hex_char(x[3:0]);
    end
    if (noisy) begin
      p = $urandom_range(0, 5);
      if (p >= 3) p++;
      chars[p] = rand8();
    end
    for (int i = 0; i < len; i++) begin
      // a clear or a read landing in the middle of a code
      if (split && i == 4) begin
        if (r[2]) send_item(rcpe_pkg::CMD_CLEAR, rand8(), r[3], r[31:10], rand8());
        else random_read();
      end
      r = $urandom;
      send_item(rcpe_pkg::CMD_CHAR, chars[i], i == len - 1, r[21:0], r[29:22]);
    end
    if (sep_ok && len > 6) begin
      aim_off[aim_wr] = off;
      aim_new[aim_wr] = newv;
      aim_cmp[aim_wr] = cmp;
      aim_cmp_on[aim_wr] = with_cmp;
      aim_wr = (aim_wr + 1) % 16;
      if (n_aim < 16) n_aim++;
    end
  endtask

  // well-formed code with random content in one of the length forms
  task automatic random_code();
    logic [31:0] r;
    logic [7:0]  nv, cv;
    logic [13:0] off;
    logic        cmp_form;
    int form, len, k;
    r = $urandom;
    nv = r[7:0];
    off = r[21:8];
    cv = rand8();
    cmp_form = 1'b0;
    form = $urandom_range(0, 9);
    if (form < 4) begin
      len = $urandom_range(7, 10);
    end else if (form < 8) begin
      len = 11;
      cmp_form = 1'b1;
    end else if (form < 9) begin
      // long code, which can also push the length counter into saturation
      len = $urandom_range(12, 20);
    end else begin
      len = 11;
    end
    // stack on an existing offset, comparing against its replacement value
    if (n_aim > 0 && $urandom_range(0, 9) < 4) begin
      k = $urandom_range(0, n_aim - 1);
      off = aim_off[k];
      cv = aim_new[k];
    end
    send_code(len, 1'b1, cmp_form, nv, off, cv,
              $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
  endtask

  task automatic random_item();
    logic [31:0] r;
    int pick;
    r = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      random_code();
    end else if (pick < 35) begin
      // broken codes: too short, or no separator at position three
      if (r[0]) send_code($urandom_range(1, 6), 1'b1, 1'b0, rand8(), r[21:8], rand8(), 1'b0, 1'b0);
      else send_code($urandom_range(7, 11), 1'b0, 1'b0, rand8(), r[21:8], rand8(), 1'b0, 1'b0);
    end else if (pick < 90) begin
      random_read();
    end else if (pick < 93) begin
      send_item(rcpe_pkg::CMD_CLEAR, r[7:0], r[8], r[30:9], rand8());
    end else if (pick < 96) begin
      send_item(CMD_SPARE, r[7:0], r[8], r[30:9], rand8());
    end else begin
      // stray character, may end or prefix a code
      send_item(rcpe_pkg::CMD_CHAR, r[7:0], r[8], r[30:9], rand8());
    end
  endtask

  task automatic run_phase(input logic ready, input int banks, input int s_pct,
                           input int r_pct, input int n_items);
    int goal;
    set_config(ready, banks);
    send_pct = s_pct;
    recv_pct = r_pct;
    goal = items_sent + n_items;
    while (items_sent < goal) random_item();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed part: all banks on, table empty
    recv_pct = 5;
    set_config(1'b1, 256);
    // extreme value and offset, plain seven character form, read in the top bank
    send_code(7, 1'b1, 1'b0, 8'hFF, 14'h3FFF, 8'h00, 1'b0, 1'b0);
    send_item(rcpe_pkg::CMD_READ, 8'h00, 1'b0, 22'h3FFFFF, 8'h00);
    // compare form at offset zero
    send_code(11, 1'b1, 1'b1, 8'h00, 14'h0000, 8'hFF, 1'b0, 1'b0);
    send_item(rcpe_pkg::CMD_READ, 8'hFF, 1'b1, 22'h000000, 8'hFF);
    send_item(rcpe_pkg::CMD_READ, 8'h00, 1'b0, 22'h000000, 8'h12);
    // clear, spare command with every bit set, one character code, read after clear
    send_item(rcpe_pkg::CMD_CLEAR, 8'h00, 1'b0, 22'h000000, 8'h00);
    send_item(CMD_SPARE, 8'hFF, 1'b1, 22'h3FFFFF, 8'hFF);
    send_item(rcpe_pkg::CMD_CHAR, 8'h00, 1'b1, 22'h000000, 8'h00);
    send_item(rcpe_pkg::CMD_READ, 8'h7F, 1'b0, 22'h3FFFFF, 8'hAB);

    // random part over several register settings
    run_phase(1'b1, 256, 20, 6, 70);
    run_phase(1'b1, 1, 0, 0, 55);       // single bank, no idling
    run_phase(1'b0, 37, 30, 8, 45);     // rom not ready, every code refused
    run_phase(1'b1, 0, 15, 6, 55);      // all cheats disabled
    run_phase(1'b1, 511, 25, 3, 55);
    run_phase(1'b1, $urandom_range(2, 255), 20, 6, 60);
    run_phase(1'b1, 256, 0, 0, 60);     // last stretch without idling

    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);

    $display("covered %0d input transactions: %0d reads, %0d codes accepted, %0d refused",
             items_sent, reads_seen, codes_taken, codes_refused);
    $display("table full hit %0d times across 8 register settings", table_full_drops);
    if (mismatch_total == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
